@@ rtl/vrba_pkg.sv @@
// Shared types, constants and elaboration-time helpers for the vector rotator.
// Used by every module in rtl/; depends on nothing else.

package vrba_pkg;

  localparam int FIELD_W        = 32;
  localparam int IN_TDATA_W     = 3 * FIELD_W;
  localparam int OUT_TDATA_W    = 2 * FIELD_W;
  localparam int TRIG_FRAC      = 30;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int ROT_STEPS_DEF  = 16;
  localparam int MAX_STEPS      = 30;

  // radians: phase = (angle * round(2^47/pi) + 2^31) >> 32
  localparam logic [45:0] RAD_PHASE_MUL = 46'd44798133900177;
  localparam int          RAD_SPLIT     = 23;
  localparam logic [63:0] RAD_ROUND     = 64'h0000_0000_8000_0000;

  // degrees: one turn is 45 * 2^19 input units
  localparam int          DEG_LO_W   = 19;
  localparam int          DEG_DIV    = 45;
  localparam logic [13:0] DEG_H_BIAS = 14'd4140;
  localparam logic [26:0] RECIP45    = 27'd95443718;
  localparam int          RECIP_SH   = 32;
  localparam logic [31:0] TURN_DIV45 = 32'd95443717;
  localparam int          TURN_REM45 = 31;
  localparam int          DEG_BIAS8  = 22;

  typedef logic [31:0] atan_tbl_t [0:MAX_STEPS-1];

  localparam atan_tbl_t ATAN_TBL = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] cx;
    logic signed [FIELD_W-1:0] cy;
    logic signed [FIELD_W-1:0] z;
    quad_t                     q;
    logic signed [FIELD_W-1:0] vx;
    logic signed [FIELD_W-1:0] vy;
  } rot_t;

  typedef struct packed {
    logic [FIELD_W-1:0] rot_y;
    logic [FIELD_W-1:0] rot_x;
  } res_t;

  // Start magnitude in Q30 that cancels the CORDIC gain of n steps.
  function automatic logic [31:0] cordic_gain(input int n);
    logic [63:0] p;
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bit_v;
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] part;
    int          i;
    p = 64'd1 << 60;
    for (i = 0; i < MAX_STEPS; i++) begin
      if (i < n) begin
        p = p + (p >> (2 * i));
      end
    end
    rem   = p;
    root  = 64'd0;
    bit_v = 64'd1 << 62;
    for (i = 0; i < 32; i++) begin
      if (bit_v > rem) begin
        bit_v = bit_v >> 2;
      end
    end
    for (i = 0; i < 32; i++) begin
      if (bit_v != 64'd0) begin
        if (rem >= root + bit_v) begin
          rem  = rem - (root + bit_v);
          root = (root >> 1) + bit_v;
        end else begin
          root = root >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    num  = (64'd1 << 60) + (root >> 1);
    quo  = 64'd0;
    part = 64'd0;
    for (i = 63; i >= 0; i--) begin
      part = {part[62:0], num[i]};
      if (part >= root) begin
        part   = part - root;
        quo[i] = 1'b1;
      end
    end
    return quo[31:0];
  endfunction

endpackage

@@ rtl/vrba_phase.sv @@
// Angle to phase front end: turns, quadrant and residual angle, six stages.
// Depends on vrba_pkg; feeds the first CORDIC cell.

module vrba_phase import vrba_pkg::*; #(
  parameter logic [31:0] START_X = 32'd0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      deg,
  input  logic                      in_vld,
  input  logic signed [FIELD_W-1:0] in_x,
  input  logic signed [FIELD_W-1:0] in_y,
  input  logic signed [FIELD_W-1:0] in_angle,
  output logic                      out_vld,
  output rot_t                      out_rot
);

  localparam int NSTG = 6;
  localparam logic signed [23:0] RAD_LO = 24'(RAD_PHASE_MUL[RAD_SPLIT-1:0]);
  localparam logic signed [23:0] RAD_HI = 24'(RAD_PHASE_MUL[45:RAD_SPLIT]);

  logic                      vld_r [0:NSTG-1];
  logic signed [FIELD_W-1:0] vx_r  [0:NSTG-2];
  logic signed [FIELD_W-1:0] vy_r  [0:NSTG-2];

  logic        [13:0]        h1_r, h1_nxt, h2_r;
  logic        [18:0]        lo1_r, lo2_r;
  logic signed [55:0]        pl1_r, pl1_nxt, ph1_r, ph1_nxt;
  logic        [40:0]        hq2_r, hq2_nxt;
  logic        [45:0]        lq2_r, lq2_nxt;
  logic        [63:0]        rsum;
  logic        [31:0]        prad2_r, prad3_r, prad4_r, prad5_r;
  logic        [13:0]        hq45;
  logic        [18:0]        lq45;
  logic        [5:0]         hm3_r, hm3_nxt, lr3_r, lr3_nxt;
  logic        [13:0]        lq3_r, lq4_r, lq5_r;
  logic        [18:0]        w4_r, w4_nxt;
  logic        [31:0]        hmk4_r, hmk4_nxt, hmk5_r;
  logic        [45:0]        wq5_r, wq5_nxt;
  logic        [31:0]        pdeg, psel;
  logic signed [29:0]        zres;
  rot_t                      rot_nxt, rot_r;

  assign h1_nxt  = 14'(in_angle >>> DEG_LO_W) + DEG_H_BIAS;
  assign pl1_nxt = in_angle * RAD_LO;
  assign ph1_nxt = in_angle * RAD_HI;

  assign hq2_nxt = 41'(h1_r) * 41'(RECIP45);
  assign lq2_nxt = 46'(lo1_r) * 46'(RECIP45);
  assign rsum    = {ph1_r[40:0], 23'd0} + 64'(pl1_r) + RAD_ROUND;

  assign hq45    = 14'(hq2_r[40:RECIP_SH]) * 14'(DEG_DIV);
  assign lq45    = 19'(lq2_r[45:RECIP_SH]) * 19'(DEG_DIV);
  assign hm3_nxt = 6'(h2_r - hq45);
  assign lr3_nxt = 6'(lo2_r - lq45);

  assign w4_nxt   = 19'({lr3_r, 13'd0}) + 19'(hm3_r) * 19'(TURN_REM45) + 19'(DEG_BIAS8);
  assign hmk4_nxt = 32'(hm3_r) * TURN_DIV45;

  assign wq5_nxt  = 46'(w4_r) * 46'(RECIP45);

  assign pdeg = hmk5_r + 32'({lq5_r, 13'd0}) + 32'(wq5_r[45:RECIP_SH]);
  assign psel = deg ? pdeg : prad5_r;
  assign zres = psel[29:0];

  always_comb begin
    rot_nxt    = '0;
    rot_nxt.cx = START_X;
    rot_nxt.cy = '0;
    rot_nxt.z  = zres;
    rot_nxt.q  = quad_t'(psel[31:30] + {1'b0, psel[29]});
    rot_nxt.vx = vx_r[NSTG-2];
    rot_nxt.vy = vy_r[NSTG-2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTG; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < NSTG; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx_r[0] <= in_x;
      vy_r[0] <= in_y;
      for (int k = 1; k < NSTG - 1; k++) begin
        vx_r[k] <= vx_r[k-1];
        vy_r[k] <= vy_r[k-1];
      end
      h1_r    <= h1_nxt;
      lo1_r   <= in_angle[DEG_LO_W-1:0];
      pl1_r   <= pl1_nxt;
      ph1_r   <= ph1_nxt;
      h2_r    <= h1_r;
      lo2_r   <= lo1_r;
      hq2_r   <= hq2_nxt;
      lq2_r   <= lq2_nxt;
      prad2_r <= rsum[63:32];
      hm3_r   <= hm3_nxt;
      lr3_r   <= lr3_nxt;
      lq3_r   <= lq2_r[45:RECIP_SH];
      prad3_r <= prad2_r;
      w4_r    <= w4_nxt;
      hmk4_r  <= hmk4_nxt;
      lq4_r   <= lq3_r;
      prad4_r <= prad3_r;
      wq5_r   <= wq5_nxt;
      hmk5_r  <= hmk4_r;
      lq5_r   <= lq4_r;
      prad5_r <= prad4_r;
      rot_r   <= rot_nxt;
    end
  end

  assign out_vld = vld_r[NSTG-1];
  assign out_rot = rot_r;

endmodule

@@ rtl/vrba_cell.sv @@
// One CORDIC rotation cell: a single micro-rotation by atan(2^-STEP), registered.
// Depends on vrba_pkg for the arctangent table and the stage record.

module vrba_cell import vrba_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_vld,
  input  rot_t in_rot,
  output logic out_vld,
  output rot_t out_rot
);

  localparam logic signed [FIELD_W-1:0] ATAN_C = ATAN_TBL[STEP];

  logic signed [FIELD_W-1:0] cx, cy, z, dx, dy;
  logic                      vld_r;
  rot_t                      rot_r, rot_nxt;

  assign cx = in_rot.cx;
  assign cy = in_rot.cy;
  assign z  = in_rot.z;
  assign dx = cy >>> STEP;
  assign dy = cx >>> STEP;

  always_comb begin
    rot_nxt = in_rot;
    if (!z[FIELD_W-1]) begin
      rot_nxt.cx = cx - dx;
      rot_nxt.cy = cy + dy;
      rot_nxt.z  = z - ATAN_C;
    end else begin
      rot_nxt.cx = cx + dx;
      rot_nxt.cy = cy - dy;
      rot_nxt.z  = z + ATAN_C;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r <= rot_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_rot = rot_r;

endmodule

@@ rtl/vrba_mix.sv @@
// Quadrant fold, vector-by-trig products, rounding and saturation to DW bits.
// Depends on vrba_pkg; takes the last CORDIC cell's record.

module vrba_mix import vrba_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_vld,
  input  rot_t in_rot,
  output logic out_vld,
  output res_t out_res
);

  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (DW - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
  localparam logic signed [63:0] RND    = 64'sd1 <<< (TRIG_FRAC - 1);

  logic signed [FIELD_W-1:0] cx, cy, vx, vy, c_sel, s_sel;
  logic signed [63:0]        pxc_r, pys_r, pxs_r, pyc_r;
  logic signed [63:0]        sx_r, sx_nxt, sy_r, sy_nxt, vsx, vsy;
  logic                      vld1_r, vld2_r;

  assign cx = in_rot.cx;
  assign cy = in_rot.cy;
  assign vx = in_rot.vx;
  assign vy = in_rot.vy;

  always_comb begin
    case (in_rot.q)
      QUAD_0: begin
        c_sel = cx;
        s_sel = cy;
      end
      QUAD_1: begin
        c_sel = -cy;
        s_sel = cx;
      end
      QUAD_2: begin
        c_sel = -cx;
        s_sel = -cy;
      end
      QUAD_3: begin
        c_sel = cy;
        s_sel = -cx;
      end
      default: begin
        c_sel = cx;
        s_sel = cy;
      end
    endcase
  end

  assign sx_nxt = pxc_r - pys_r + RND;
  assign sy_nxt = pxs_r + pyc_r + RND;

  assign vsx = sx_r >>> TRIG_FRAC;
  assign vsy = sy_r >>> TRIG_FRAC;

  always_comb begin
    if (vsx > SAT_HI) begin
      out_res.rot_x = SAT_HI[FIELD_W-1:0];
    end else if (vsx < SAT_LO) begin
      out_res.rot_x = SAT_LO[FIELD_W-1:0];
    end else begin
      out_res.rot_x = vsx[FIELD_W-1:0];
    end
    if (vsy > SAT_HI) begin
      out_res.rot_y = SAT_HI[FIELD_W-1:0];
    end else if (vsy < SAT_LO) begin
      out_res.rot_y = SAT_LO[FIELD_W-1:0];
    end else begin
      out_res.rot_y = vsy[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxc_r <= vx * c_sel;
      pys_r <= vy * s_sel;
      pxs_r <= vx * s_sel;
      pyc_r <= vy * c_sel;
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
    end
  end

  assign out_vld = vld2_r;

endmodule

@@ rtl/vrba_skid.sv @@
// Output register with one skid entry; its fill state stalls the pipeline.
// Depends on vrba_pkg for the result record.

module vrba_skid import vrba_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   p_vld,
  input  res_t                   p_res,
  output logic                   en,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic out_vld_r, out_vld_nxt, skid_vld_r, skid_vld_nxt;
  logic out_free, push;
  res_t out_res_r, skid_res_r;

  assign en       = !skid_vld_r;
  assign push     = en && p_vld;
  assign out_free = !out_vld_r || out_tready;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (out_free) begin
      out_vld_nxt  = skid_vld_r || push;
      skid_vld_nxt = 1'b0;
    end else if (push) begin
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res_r <= skid_vld_r ? skid_res_r : p_res;
    end else if (push) begin
      skid_res_r <= p_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_res_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held while output register empty");

  a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready && push) |=> skid_vld_r)
    else $error("pipeline result dropped while output stalled");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && out_tready) |=> (out_vld_r && !skid_vld_r))
    else $error("skid entry not moved to output after transfer");

endmodule

@@ rtl/vector_rotate_by_angle.sv @@
// Rotates (x, y) by an angle given in radians or degrees, Q16.16 fixed point with
// saturated results. Fully pipelined: one item per cycle while in_tready is high; from
// input transfer to result an item passes through the angle-to-phase reduction
// stages, one cell per CORDIC step, two multiply/round stages and
// the output register. A one-entry skid lets input transfers go on while a result
// waits; when it fills, in_tready drops until out_tready returns.

module vector_rotate_by_angle import vrba_pkg::*; #(
  parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
  parameter int ROTATION_STEPS = ROT_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,  // angle_in_degrees
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,     // vec_x, vec_y, angle
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata     // rot_x, rot_y
);

  localparam int DW    = (DATA_WIDTH > FIELD_W) ? FIELD_W : DATA_WIDTH;
  localparam int NSTEP = (ROTATION_STEPS < 1) ? 1 :
                         ((ROTATION_STEPS > MAX_STEPS) ? MAX_STEPS : ROTATION_STEPS);
  localparam logic [31:0] START_X = cordic_gain(NSTEP);

  logic                      angle_deg_r;
  logic                      en;
  logic signed [DW-1:0]      x_w, y_w, a_w;
  logic signed [FIELD_W-1:0] x_e, y_e, a_e;
  logic                      stg_vld [0:NSTEP];
  rot_t                      stg_rot [0:NSTEP];
  logic                      mix_vld;
  res_t                      mix_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_deg_r <= 1'b0;
    end else if (cfg_wr_en) begin
      angle_deg_r <= cfg_wr_data;
    end
  end

  assign x_w = in_tdata[DW-1:0];
  assign y_w = in_tdata[FIELD_W+DW-1:FIELD_W];
  assign a_w = in_tdata[2*FIELD_W+DW-1:2*FIELD_W];
  assign x_e = x_w;
  assign y_e = y_w;
  assign a_e = a_w;

  assign in_tready = en;

  vrba_phase #(
    .START_X (START_X)
  ) u_phase (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .deg      (angle_deg_r),
    .in_vld   (in_tvalid),
    .in_x     (x_e),
    .in_y     (y_e),
    .in_angle (a_e),
    .out_vld  (stg_vld[0]),
    .out_rot  (stg_rot[0])
  );

  for (genvar g = 0; g < NSTEP; g++) begin : g_cell
    vrba_cell #(
      .STEP (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (stg_vld[g]),
      .in_rot  (stg_rot[g]),
      .out_vld (stg_vld[g+1]),
      .out_rot (stg_rot[g+1])
    );
  end

  vrba_mix #(
    .DW (DW)
  ) u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (stg_vld[NSTEP]),
    .in_rot  (stg_rot[NSTEP]),
    .out_vld (mix_vld),
    .out_res (mix_res)
  );

  vrba_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .p_vld      (mix_vld),
    .p_res      (mix_res),
    .en         (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
